@@ rtl/lzwc_pkg.sv @@
// shared types, constants and helpers for the lzw byte compressor
`default_nettype none

package lzwc_pkg;

   // narrowest code width ever emitted
   localparam logic [4:0] MIN_WIDTH = 5'd9;
   // reset value of the max code width register
   localparam logic [3:0] CSR_RESET_BITS = 4'd12;
   // result fifo
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_BITS = 3;

   typedef enum logic [1:0] {
      MODE_CLEAR,
      MODE_RUN,
      MODE_FLUSH
   } mode_type;

   typedef struct packed {
      logic [11:0] out_code;
      logic [3:0]  out_width;
      logic        final_code;
   } rsp_word_type;

   // memory port strobes from the controller to the dictionary
   typedef struct packed {
      logic map_rd;
      logic map_wr;
      logic own_rd;
      logic own_wr;
   } dict_ctl_type;

   // clamp a bit count into min_width..top
   function automatic logic [4:0] clamp_width(input logic [4:0] w, input logic [4:0] top);
      logic [4:0] r;
      r = w;
      if (r < MIN_WIDTH) r = MIN_WIDTH;
      if (r > top) r = top;
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lzwc_channels.sv @@
// handshake channel interfaces of the lzw byte compressor
`default_nettype none

interface lzwc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;
   modport source(output valid, data_byte, end_of_data, input ready);
   modport sink(input valid, data_byte, end_of_data, output ready);
endinterface

interface lzwc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] out_code;
   logic [3:0]  out_width;
   logic        final_code;
   modport source(output valid, out_code, out_width, final_code, input ready);
   modport sink(input valid, out_code, out_width, final_code, output ready);
endinterface

interface lzwc_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] width_limit;
   modport source(output valid, width_limit, input ready);
   modport sink(input valid, width_limit, output ready);
endinterface

`default_nettype wire

@@ rtl/lzwc_dict.sv @@
// child map and code owner memories with write-to-read forwarding
`default_nettype none

module lzwc_dict
   import lzwc_pkg::*;
#(
   parameter int CODE_BITS = 12,
   parameter int ADDR_BITS = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dict_ctl_type         ctl,
   input  wire logic [ADDR_BITS-1:0] map_rd_addr,
   input  wire logic [ADDR_BITS-1:0] map_wr_addr,
   input  wire logic [CODE_BITS-1:0] map_wr_data,
   input  wire logic [CODE_BITS-1:0] own_rd_addr,
   input  wire logic [CODE_BITS-1:0] own_wr_addr,
   input  wire logic [ADDR_BITS-1:0] own_wr_data,
   output logic      [CODE_BITS-1:0] child_code,
   output logic      [ADDR_BITS-1:0] own_rd_data
);

   localparam int MAP_DEPTH = 1 << ADDR_BITS;
   localparam int OWN_DEPTH = 1 << CODE_BITS;

   logic [CODE_BITS-1:0] map_mem [MAP_DEPTH];
   logic [ADDR_BITS-1:0] own_mem [OWN_DEPTH];

   logic [CODE_BITS-1:0] map_q_ff;
   logic [CODE_BITS-1:0] fwd_data_ff;
   logic                 fwd_hit_ff;
   logic [ADDR_BITS-1:0] own_q_ff;

   // child map: read returns old data on a same-address write
   always_ff @(posedge clock) begin
      if (ctl.map_wr) begin
         map_mem[map_wr_addr] <= map_wr_data;
      end
      if (ctl.map_rd) begin
         map_q_ff <= map_mem[map_rd_addr];
      end
   end

   // remember a colliding write so the lookup sees the new entry
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (ctl.map_rd) begin
         fwd_hit_ff <= ctl.map_wr && (map_wr_addr == map_rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.map_rd) begin
         fwd_data_ff <= map_wr_data;
      end
   end

   // slot that each assigned code lives in, for the end of stream sweep
   always_ff @(posedge clock) begin
      if (ctl.own_wr) begin
         own_mem[own_wr_addr] <= own_wr_data;
      end
      if (ctl.own_rd) begin
         own_q_ff <= own_mem[own_rd_addr];
      end
   end

   assign child_code  = fwd_hit_ff ? fwd_data_ff : map_q_ff;
   assign own_rd_data = own_q_ff;

endmodule

`default_nettype wire

@@ rtl/lzwc_rsp_fifo.sv @@
// result word fifo taking up to two words per cycle
`default_nettype none

module lzwc_rsp_fifo
   import lzwc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         push_cnt,
   input  wire rsp_word_type       push0,
   input  wire rsp_word_type       push1,
   input  wire logic               pop,
   output logic                    head_valid,
   output rsp_word_type            head_word,
   output logic [RSP_PTR_BITS:0]   count
);

   rsp_word_type              words_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_BITS-1:0]   head_ff, head_in;
   logic [RSP_PTR_BITS-1:0]   tail_ff, tail_in;
   logic [RSP_PTR_BITS:0]     count_ff, count_in;
   logic [RSP_PTR_BITS-1:0]   tail_next;
   logic                      do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign tail_next = tail_ff + RSP_PTR_BITS'(1);

   always_comb begin
      head_in  = do_pop ? head_ff + RSP_PTR_BITS'(1) : head_ff;
      tail_in  = tail_ff + RSP_PTR_BITS'(push_cnt);
      count_in = count_ff + (RSP_PTR_BITS + 1)'(push_cnt) - (RSP_PTR_BITS + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         words_ff[tail_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         words_ff[tail_next] <= push1;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_word  = words_ff[head_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

@@ rtl/lzw_byte_compressor.sv @@
// top level of the lzw byte compressor with variable code width
//
//  channel  dir  payload                               moves
//  req_ch   in   data_byte[7:0], end_of_data           one input byte per word
//  rsp_ch   out  out_code[11:0], out_width[3:0], final one emitted code per word
//  csr_ch   in   width_limit[3:0]                      max code width register
//
// one byte per cycle sustained when not stalled: the child map read issued at acceptance
// resolves in the next cycle, and its result feeds the next byte's address
// each byte emits zero to two words; bytes stall while the result fifo has
// no room for two more words beyond what the resolving byte pushes
// after a word with end_of_data, a sweep clears the used child map entries;
// no byte is taken meanwhile
// after reset, a clearing pass zeroes all 2^(MAX_CODE_BITS + log2(ALPHABET_SIZE))
// child map entries; csr writes always taken
`default_nettype none

module lzw_byte_compressor
   import lzwc_pkg::*;
#(
   parameter int MAX_CODE_BITS = 12,
   parameter int ALPHABET_SIZE = 256
) (
   input wire logic  clock,
   input wire logic  reset,
   lzwc_req_if.sink   req_ch,
   lzwc_rsp_if.source rsp_ch,
   lzwc_csr_if.sink   csr_ch
);

   localparam int BYTE_BITS = $clog2(ALPHABET_SIZE);
   localparam int CODE_BITS = MAX_CODE_BITS;
   localparam int ADDR_BITS = CODE_BITS + BYTE_BITS;
   localparam int NF_BITS   = CODE_BITS + 1;
   localparam logic [8:0]           ALPHA_LIM  = 9'(ALPHABET_SIZE);
   localparam logic [BYTE_BITS-1:0] ALPHA_TOP  = BYTE_BITS'(ALPHABET_SIZE - 1);
   localparam logic [NF_BITS-1:0]   ALPHA_CODE = NF_BITS'(ALPHABET_SIZE);
   localparam logic [NF_BITS-1:0]   CODE_SPACE = NF_BITS'(1) << CODE_BITS;
   localparam logic [4:0]           ROOT_BITS  = 5'(BYTE_BITS);
   localparam logic [4:0]           TOP_BITS   = 5'(MAX_CODE_BITS);
   localparam logic [RSP_PTR_BITS+1:0] ROOM_LIM = (RSP_PTR_BITS + 2)'(RSP_FIFO_DEPTH - 2);

   // control and phrase state
   mode_type             mode_ff, mode_in;
   logic [ADDR_BITS-1:0] clr_addr_ff;
   logic [NF_BITS-1:0]   sweep_code_ff;
   logic                 sweep_pend_ff;
   logic [3:0]           cfg_ff;
   logic [CODE_BITS-1:0] phrase_ff;
   logic                 at_root_ff;
   logic [NF_BITS-1:0]   next_free_ff;
   logic [4:0]           code_bits_ff;

   // byte whose lookup resolves this cycle
   logic                 look_valid_ff;
   logic                 look_lookup_ff;
   logic [BYTE_BITS-1:0] look_byte_ff;
   logic                 look_last_ff;

   // datapath
   logic [BYTE_BITS-1:0] req_byte;
   logic [CODE_BITS-1:0] child;
   logic                 hit, miss, can_add;
   logic [4:0]           eff_bits;
   logic [NF_BITS-1:0]   limit;
   logic [NF_BITS-1:0]   next_free_post;
   logic [4:0]           code_bits_post;
   logic [4:0]           width_pre, width_post;
   logic [CODE_BITS-1:0] phrase_post;
   logic [ADDR_BITS-1:0] slot_write;
   logic [CODE_BITS-1:0] cur_phrase;
   logic                 cur_root;
   logic                 req_ready, accept;
   rsp_word_type         miss_word, final_word, push0;
   logic [1:0]           push_cnt;
   logic [RSP_PTR_BITS:0] rsp_count;
   rsp_word_type         head_word;
   logic                 head_valid;

   // dictionary port
   dict_ctl_type         ctl;
   logic [ADDR_BITS-1:0] map_rd_addr, map_wr_addr;
   logic [CODE_BITS-1:0] map_wr_data;
   logic [CODE_BITS-1:0] own_rd_addr, own_wr_addr;
   logic [ADDR_BITS-1:0] own_wr_data, own_rd_data;

   // bytes outside the alphabet fold onto its last symbol
   assign req_byte = ({1'b0, req_ch.data_byte} < ALPHA_LIM) ?
                     req_ch.data_byte[BYTE_BITS-1:0] : ALPHA_TOP;

   // resolve the pending lookup
   always_comb begin
      eff_bits       = clamp_width({1'b0, cfg_ff}, TOP_BITS);
      limit          = NF_BITS'(1) << eff_bits;
      hit            = look_lookup_ff && (child != '0);
      miss           = look_lookup_ff && !hit;
      can_add        = look_valid_ff && miss && (next_free_ff < limit);
      next_free_post = can_add ? next_free_ff + NF_BITS'(1) : next_free_ff;
      code_bits_post = code_bits_ff;
      // width grows when the code just handed out is a power of two
      if (can_add && (next_free_ff == (NF_BITS'(1) << code_bits_ff))) begin
         code_bits_post = code_bits_ff + 5'd1;
      end
      width_pre   = clamp_width(code_bits_ff, eff_bits);
      width_post  = clamp_width(code_bits_post, eff_bits);
      phrase_post = hit ? child : CODE_BITS'(look_byte_ff);
      slot_write  = {phrase_ff, look_byte_ff};
   end

   // result words of the resolving byte
   always_comb begin
      miss_word.out_code    = 12'(phrase_ff);
      miss_word.out_width   = 4'(width_pre);
      miss_word.final_code  = 1'b0;
      final_word.out_code   = 12'(phrase_post);
      final_word.out_width  = 4'(width_post);
      final_word.final_code = 1'b1;
      push0    = miss ? miss_word : final_word;
      push_cnt = 2'd0;
      if (look_valid_ff) begin
         push_cnt = 2'(miss) + 2'(look_last_ff);
      end
   end

   // phrase seen by the byte being offered now
   assign cur_phrase = look_valid_ff ? phrase_post : phrase_ff;
   assign cur_root   = look_valid_ff ? 1'b0 : at_root_ff;

   // next state
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_CLEAR: begin
            if (clr_addr_ff == '1) mode_in = MODE_RUN;
         end
         MODE_RUN: begin
            if (look_valid_ff && look_last_ff) mode_in = MODE_FLUSH;
         end
         MODE_FLUSH: begin
            if (!(sweep_code_ff < next_free_ff) && !sweep_pend_ff) mode_in = MODE_RUN;
         end
         default: mode_in = MODE_RUN;
      endcase
   end

   // outputs: handshake and memory strobes
   always_comb begin
      req_ready   = 1'b0;
      ctl         = '0;
      map_rd_addr = {cur_phrase, req_byte};
      map_wr_addr = slot_write;
      map_wr_data = next_free_ff[CODE_BITS-1:0];
      own_rd_addr = sweep_code_ff[CODE_BITS-1:0];
      own_wr_addr = next_free_ff[CODE_BITS-1:0];
      own_wr_data = slot_write;
      case (mode_ff)
         MODE_CLEAR: begin
            ctl.map_wr  = 1'b1;
            map_wr_addr = clr_addr_ff;
            map_wr_data = '0;
         end
         MODE_RUN: begin
            // hold off behind a last byte and when the fifo could overflow
            req_ready = !(look_valid_ff && look_last_ff) &&
                        (({1'b0, rsp_count} + (RSP_PTR_BITS + 2)'(push_cnt)) <= ROOM_LIM);
            ctl.map_rd = req_ch.valid && req_ready && !cur_root;
            ctl.map_wr = can_add;
            ctl.own_wr = can_add;
         end
         MODE_FLUSH: begin
            ctl.own_rd  = sweep_code_ff < next_free_ff;
            ctl.map_wr  = sweep_pend_ff;
            map_wr_addr = own_rd_data;
            map_wr_data = '0;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept       = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_CLEAR;
         clr_addr_ff    <= '0;
         sweep_code_ff  <= ALPHA_CODE;
         sweep_pend_ff  <= 1'b0;
         cfg_ff         <= CSR_RESET_BITS;
         phrase_ff      <= '0;
         at_root_ff     <= 1'b1;
         next_free_ff   <= ALPHA_CODE;
         code_bits_ff   <= ROOT_BITS;
         look_valid_ff  <= 1'b0;
         look_lookup_ff <= 1'b0;
         look_last_ff   <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         if (csr_ch.valid) begin
            cfg_ff <= csr_ch.width_limit;
         end
         if (mode_ff == MODE_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
         end
         // stage the accepted byte for its lookup
         look_valid_ff <= accept;
         if (accept) begin
            look_lookup_ff <= !cur_root;
            look_last_ff   <= req_ch.end_of_data;
         end
         if (look_valid_ff) begin
            next_free_ff <= next_free_post;
            code_bits_ff <= code_bits_post;
            if (look_last_ff) begin
               phrase_ff     <= '0;
               at_root_ff    <= 1'b1;
               sweep_code_ff <= ALPHA_CODE;
            end else begin
               phrase_ff  <= phrase_post;
               at_root_ff <= 1'b0;
            end
         end
         // end of stream sweep: owner read, then child map clear
         if (mode_ff == MODE_FLUSH) begin
            sweep_pend_ff <= ctl.own_rd;
            if (ctl.own_rd) begin
               sweep_code_ff <= sweep_code_ff + NF_BITS'(1);
            end
            if (mode_in == MODE_RUN) begin
               next_free_ff <= ALPHA_CODE;
               code_bits_ff <= ROOT_BITS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         look_byte_ff <= req_byte;
      end
   end

   lzwc_dict #(
      .CODE_BITS(CODE_BITS),
      .ADDR_BITS(ADDR_BITS)
   ) u_dict (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .map_rd_addr(map_rd_addr),
      .map_wr_addr(map_wr_addr),
      .map_wr_data(map_wr_data),
      .own_rd_addr(own_rd_addr),
      .own_wr_addr(own_wr_addr),
      .own_wr_data(own_wr_data),
      .child_code(child),
      .own_rd_data(own_rd_data)
   );

   lzwc_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push_cnt(push_cnt),
      .push0(push0),
      .push1(final_word),
      .pop(rsp_ch.ready),
      .head_valid(head_valid),
      .head_word(head_word),
      .count(rsp_count)
   );

   assign rsp_ch.valid      = head_valid;
   assign rsp_ch.out_code   = head_word.out_code;
   assign rsp_ch.out_width  = head_word.out_width;
   assign rsp_ch.final_code = head_word.final_code;

   // a last byte blocks the next one while it resolves
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.end_of_data) |=> !req_ch.ready)
      else $error("byte accepted behind a last byte");

   // never more codes than the code space
   a_code_space: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= CODE_SPACE)
      else $error("next free code beyond code space");

   // the result fifo never overflows
   a_fifo_room: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rsp_count} + (RSP_PTR_BITS + 2)'(push_cnt)) <= (RSP_PTR_BITS + 2)'(RSP_FIFO_DEPTH))
      else $error("result fifo overflow");

   // the sweep leaves a fresh dictionary
   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_FLUSH && mode_in == MODE_RUN) |=>
         (next_free_ff == ALPHA_CODE) && at_root_ff && (code_bits_ff == ROOT_BITS))
      else $error("stream state not restored after sweep");

endmodule

`default_nettype wire
